FILE: rtl/buddy_page_allocator_defines.svh
// Assertion helpers for the buddy page allocator.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BPA_ASSERT_NXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) trig |=> cons) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_NXT(lbl, trig, cons, msg)
`endif
`endif

FILE: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int LAST_ORD  = 10;
  localparam int NUM_ORD   = LAST_ORD + 1;
  localparam int NUM_PAGES = 1024;
  localparam int PAGE_W    = 10;
  localparam int LINK_W    = 11;
  localparam int CNT_W     = 11;
  localparam int ORD_W     = 4;
  localparam int META_W    = ORD_W + 1;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_UNL_RD,
    S_UNL_WR,
    S_SPLIT,
    S_FCHK,
    S_FMETA,
    S_PUSH,
    S_PUSH_LINK,
    S_FINISH
  } fsm_e;

  // one update of the per-order list heads and the free page total
  typedef struct packed {
    logic              set_head;
    logic              inc;
    logic              dec;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] head_val;
  } list_cmd_t;

  // smallest order whose block holds cnt pages
  function automatic logic [ORD_W-1:0] ceil_order(input logic [CNT_W-1:0] cnt);
    logic [ORD_W-1:0] r;
    r = ORD_W'(LAST_ORD);
    for (int i = LAST_ORD; i >= 0; i--) begin
      if ((CNT_W'(1) << i) >= cnt) r = ORD_W'(i);
    end
    return r;
  endfunction

  // largest order whose block fits in cnt pages
  function automatic logic [ORD_W-1:0] floor_order(input logic [CNT_W-1:0] cnt);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i <= LAST_ORD; i++) begin
      if (cnt[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/bpa_ram.sv
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bpa_free_lists.sv
`timescale 1ns / 1ps
module bpa_free_lists import bpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  list_cmd_t         cmd_i,
  input  logic [ORD_W-1:0]  rd_ord_i,
  output logic [LINK_W-1:0] rd_head_o,
  output logic [CNT_W-1:0]  total_o
);

  logic [LINK_W-1:0] head_q [NUM_ORD];
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  size;

  assign size = CNT_W'(1) << cmd_i.ord;

  always_comb begin
    total_d = total_q;
    if (cmd_i.inc) total_d = total_q + size;
    else if (cmd_i.dec) total_d = total_q - size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NUM_ORD; i++) head_q[i] <= NULL_LINK;
    end else begin
      total_q <= total_d;
      if (cmd_i.set_head && (cmd_i.ord <= ORD_W'(LAST_ORD))) begin
        head_q[cmd_i.ord] <= cmd_i.head_val;
      end
    end
  end

  assign rd_head_o = (rd_ord_i <= ORD_W'(LAST_ORD)) ? head_q[rd_ord_i] : NULL_LINK;
  assign total_o   = total_q;

endmodule

FILE: rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// A rejected request goes straight to the result; add cuts the run into blocks and pushes each;
// allocate scans the orders upward from the target, then splits the block it finds down to the target,
// or ends when nothing fits; free merges the block with its free buddy order by order, then pushes it.
// One request at a time: the next is taken in the cycle after the result is registered.
// Reset: asynchronous, active low; then a pass over every page clears the free flags, during
// which no request is taken.
`include "buddy_page_allocator_defines.svh"
module buddy_page_allocator import bpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [PAGE_W-1:0] page_index_i,
  input  logic [CNT_W-1:0]  page_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [PAGE_W-1:0] block_index_o,
  output logic [CNT_W-1:0]  total_free_o
);

  // control
  fsm_e              state_q, state_d;
  logic [PAGE_W:0]   clr_q;
  logic              out_valid_q;
  logic              in_fire;

  // request context
  logic [1:0]        op_q;
  logic [PAGE_W-1:0] p_q;        // add: next block start, free: merged block start
  logic [CNT_W-1:0]  left_q;     // add: pages still to cut
  logic [ORD_W-1:0]  ord_q;      // order being worked on
  logic [ORD_W-1:0]  tgt_q;      // allocate: target order
  logic [PAGE_W-1:0] w_idx_q;    // block to push
  logic [PAGE_W-1:0] u_idx_q;    // block to unlink
  logic [LINK_W-1:0] nx_q;       // old head seen by a push
  logic [1:0]        res_st_q;
  logic [PAGE_W-1:0] res_blk_q;

  // result register
  logic [1:0]        status_q;
  logic [PAGE_W-1:0] block_q;
  logic [CNT_W-1:0]  total_q;

  // memories
  logic              meta_we, meta_re;
  logic [PAGE_W-1:0] meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              next_we, next_re;
  logic [PAGE_W-1:0] next_waddr;
  logic [LINK_W-1:0] next_wdata, next_rdata;
  logic              prev_we;
  logic [PAGE_W-1:0] prev_waddr;
  logic [LINK_W-1:0] prev_wdata, prev_rdata;

  list_cmd_t         lcmd;
  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  free_pages;

  // decode of the incoming request
  logic [ORD_W-1:0]  in_ord;
  logic [PAGE_W+1:0] add_end, free_end;
  logic              add_ok, alloc_ok, free_ok;
  logic [ORD_W-1:0]  add_ord;
  logic [LINK_W-1:0] half;
  logic [PAGE_W-1:0] bud;
  logic              fin_go;
  fsm_e              after_push;

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_ord   = ceil_order(page_count_i);
  assign add_end  = {2'b0, page_index_i} + {1'b0, page_count_i};
  assign free_end = {2'b0, page_index_i} + ((PAGE_W+2)'(1) << in_ord);
  assign add_ok   = (opcode_i == OP_ADD) && (page_count_i != '0) &&
                    (add_end <= (PAGE_W+2)'(NUM_PAGES));
  assign alloc_ok = (opcode_i == OP_ALLOC) && (page_count_i != '0) &&
                    (page_count_i <= CNT_W'(1 << LAST_ORD));
  assign free_ok  = (opcode_i == OP_FREE) && (page_count_i != '0) &&
                    (page_count_i <= CNT_W'(1 << LAST_ORD)) &&
                    (free_end <= (PAGE_W+2)'(NUM_PAGES));

  assign add_ord  = floor_order(left_q);
  assign half     = {1'b0, res_blk_q} + (LINK_W'(1) << (ord_q - ORD_W'(1)));
  assign bud      = p_q ^ (PAGE_W'(1) << ord_q);
  assign fin_go   = !out_valid_q || out_ready_i;

  // where a finished push hands control back
  always_comb begin
    case (op_q)
      OP_ADD:   after_push = (left_q == '0) ? S_FINISH : S_ADD;
      OP_ALLOC: after_push = S_SPLIT;
      default:  after_push = S_FINISH;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == (PAGE_W+1)'(NUM_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (add_ok) state_d = S_ADD;
          else if (alloc_ok) state_d = S_SCAN;
          else if (free_ok) state_d = S_FCHK;
          else state_d = S_FINISH;
        end
      end
      S_ADD: state_d = S_PUSH;
      S_SCAN: begin
        if (ord_q > ORD_W'(LAST_ORD)) state_d = S_FINISH;
        else if (!head[PAGE_W]) state_d = S_UNL_RD;
      end
      S_UNL_RD: state_d = S_UNL_WR;
      S_UNL_WR: state_d = (op_q == OP_ALLOC) ? S_SPLIT : S_FCHK;
      S_SPLIT: begin
        if (ord_q <= tgt_q) state_d = S_FINISH;
        else if (!half[PAGE_W]) state_d = S_PUSH;
      end
      S_FCHK: state_d = (ord_q < ORD_W'(LAST_ORD)) ? S_FMETA : S_PUSH;
      S_FMETA: begin
        if (meta_rdata[ORD_W] && (meta_rdata[ORD_W-1:0] == ord_q) && !head[PAGE_W]) begin
          state_d = S_UNL_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:      state_d = head[PAGE_W] ? after_push : S_PUSH_LINK;
      S_PUSH_LINK: state_d = after_push;
      S_FINISH:    if (fin_go) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // memory and list controls
  always_comb begin
    in_ready_o = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = w_idx_q;
    meta_wdata = {1'b1, ord_q};
    meta_re    = 1'b0;
    meta_raddr = bud;
    next_we    = 1'b0;
    next_waddr = w_idx_q;
    next_wdata = head;
    next_re    = 1'b0;
    prev_we    = 1'b0;
    prev_waddr = w_idx_q;
    prev_wdata = NULL_LINK;
    lcmd       = '{set_head: 1'b0, inc: 1'b0, dec: 1'b0, ord: ord_q,
                   head_val: {1'b0, w_idx_q}};
    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q[PAGE_W-1:0];
        meta_wdata = '0;
      end
      S_IDLE: in_ready_o = 1'b1;
      S_UNL_RD: next_re = 1'b1;
      S_UNL_WR: begin
        // drop the block: bridge its neighbors, clear its flag
        meta_we    = 1'b1;
        meta_waddr = u_idx_q;
        meta_wdata = {1'b0, ord_q};
        next_we    = !prev_rdata[PAGE_W];
        next_waddr = prev_rdata[PAGE_W-1:0];
        next_wdata = next_rdata;
        prev_we    = !next_rdata[PAGE_W];
        prev_waddr = next_rdata[PAGE_W-1:0];
        prev_wdata = prev_rdata;
        lcmd.set_head = prev_rdata[PAGE_W];
        lcmd.head_val = next_rdata;
        lcmd.dec      = 1'b1;
      end
      S_FCHK: meta_re = (ord_q < ORD_W'(LAST_ORD));
      S_PUSH: begin
        meta_we       = 1'b1;
        next_we       = 1'b1;
        prev_we       = 1'b1;
        lcmd.set_head = 1'b1;
        lcmd.inc      = 1'b1;
      end
      S_PUSH_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = nx_q[PAGE_W-1:0];
        prev_wdata = {1'b0, w_idx_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_FINISH && fin_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // request context and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_q      <= opcode_i;
          p_q       <= page_index_i;
          left_q    <= page_count_i;
          ord_q     <= in_ord;
          tgt_q     <= in_ord;
          res_blk_q <= '0;
          if (add_ok || free_ok) res_st_q <= ST_OK;
          else if (alloc_ok) res_st_q <= ST_NOMEM;
          else res_st_q <= ST_BAD;
        end
      end
      S_ADD: begin
        // cut the largest block that fits the rest of the run
        ord_q   <= add_ord;
        w_idx_q <= p_q;
        p_q     <= p_q + (PAGE_W'(1) << add_ord);
        left_q  <= left_q - (CNT_W'(1) << add_ord);
      end
      S_SCAN: begin
        if (ord_q <= ORD_W'(LAST_ORD)) begin
          if (!head[PAGE_W]) begin
            u_idx_q   <= head[PAGE_W-1:0];
            res_blk_q <= head[PAGE_W-1:0];
            res_st_q  <= ST_OK;
          end else begin
            ord_q <= ord_q + 1'b1;
          end
        end
      end
      S_UNL_WR: begin
        if (op_q == OP_FREE) begin
          if (u_idx_q < p_q) p_q <= u_idx_q;
          ord_q <= ord_q + 1'b1;
        end
      end
      S_SPLIT: begin
        // hand the upper half back one order down
        if (ord_q > tgt_q) begin
          ord_q   <= ord_q - 1'b1;
          w_idx_q <= half[PAGE_W-1:0];
        end
      end
      S_FCHK: begin
        u_idx_q <= bud;
        w_idx_q <= p_q;
      end
      S_PUSH: nx_q <= head;
      S_FINISH: begin
        if (fin_go) begin
          status_q <= res_st_q;
          block_q  <= (res_st_q == ST_OK) ? res_blk_q : '0;
          total_q  <= free_pages;
        end
      end
      default: ;
    endcase
  end

  // free flag and order per page
  bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (next_re),
    .raddr_i (u_idx_q),
    .rdata_o (next_rdata)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (next_re),
    .raddr_i (u_idx_q),
    .rdata_o (prev_rdata)
  );

  bpa_free_lists u_lists (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (lcmd),
    .rd_ord_i  (ord_q),
    .rd_head_o (head),
    .total_o   (free_pages)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign block_index_o = block_q;
  assign total_free_o  = total_q;

  `BPA_ASSERT(a_no_req_in_clear, (state_q == S_CLEAR) |-> !in_ready_o, "request taken during clear")
  `BPA_ASSERT(a_blk_zero_on_err, (out_valid_o && (status_o != ST_OK)) |-> (block_index_o == '0), "block index set on failed request")
  `BPA_ASSERT_NXT(a_fire_leaves_idle, in_fire, (state_q != S_IDLE), "sequencer stayed idle after request")
  `BPA_ASSERT(a_unlink_after_read, (state_q == S_UNL_WR) |-> ($past(state_q) == S_UNL_RD), "unlink write without link read")

endmodule
